// ===== design/tile_cache_lru_lookup_unit_macros.svh =====
// Assertion macros used by the tile cache lookup RTL.
`ifndef TILE_CACHE_LRU_LOOKUP_UNIT_MACROS_SVH
`define TILE_CACHE_LRU_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define TCL_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define TCL_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/tcl_pkg.sv =====
// Shared types and constants of the tile cache lookup.
package tcl_pkg;

   localparam int COORD_W   = 29;
   localparam int RUNG_W    = 6;
   localparam int OFFSET_W  = 32;
   localparam int STAMP_W   = 32;
   localparam int COUNT_W   = 17;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 29;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BLANK   = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_HIT     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FILL    = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FAIL    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM_RUNG = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_ORG   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_ORG   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 3'd4;

   // one cache slot as held in the tag memory
   typedef struct packed {
      logic [RUNG_W-1:0]         rung;
      logic signed [COORD_W-1:0] col;
      logic signed [COORD_W-1:0] row;
      logic [STAMP_W-1:0]        stamp;
   } tcl_entry_type;

   typedef struct packed {
      logic [RUNG_W-1:0]         rung;
      logic signed [COORD_W-1:0] col_org;
      logic signed [COORD_W-1:0] row_org;
      logic [COUNT_W-1:0]        cols;
      logic [COUNT_W-1:0]        rows;
   } tcl_cfg_type;

   typedef struct packed {
      logic                done;
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } tcl_result_type;

endpackage

// ===== design/tcl_ifs.sv =====
// Request and response channel interfaces of the tile cache lookup.
interface tcl_req_if;
   import tcl_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] tile_col;
   logic signed [COORD_W-1:0] tile_row;
   logic [OFFSET_W-1:0]       index_offset;
   logic                      read_ok;

   modport source (output valid, tile_col, tile_row, index_offset, read_ok, input ready);
   modport sink   (input valid, tile_col, tile_row, index_offset, read_ok, output ready);
endinterface

interface tcl_rsp_if;
   import tcl_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;

   modport source (output valid, status, slot, input ready);
   modport sink   (input valid, status, slot, output ready);
endinterface

// ===== design/tcl_tag_ram.sv =====
// Slot tag and stamp memory: one write port, one read port, registered read.
module tcl_tag_ram #(
   parameter int DEPTH = 12,
   parameter int AW    = 4
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  tcl_pkg::tcl_entry_type wr_data,
   input  logic [AW-1:0]          rd_addr,
   output tcl_pkg::tcl_entry_type rd_data
);
   import tcl_pkg::*;

   tcl_entry_type mem [DEPTH];
   tcl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tcl_ctrl.sv =====
// Lookup sequencer: grid check, slot scan with victim search, write-back.
module tcl_ctrl #(
   parameter int SLOTS = 12,
   parameter int IW    = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   tcl_req_if.sink                 req_chan,
   input  tcl_pkg::tcl_cfg_type    cfg,
   input  logic                    out_free,
   output tcl_pkg::tcl_result_type result,
   output logic                    ram_wr_en,
   output logic [IW-1:0]           ram_wr_addr,
   output tcl_pkg::tcl_entry_type  ram_wr_data,
   output logic [IW-1:0]           ram_rd_addr,
   input  tcl_pkg::tcl_entry_type  ram_rd_data
);
   import tcl_pkg::*;

   `include "tile_cache_lru_lookup_unit_macros.svh"

   localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_SCAN, ST_UPDATE} state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] col;
      logic signed [COORD_W-1:0] row;
      logic [OFFSET_W-1:0]       offset;
      logic                      read_ok;
   } req_type;

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [IW-1:0]       rd_idx_ff, rd_idx_in;
   logic [IW-1:0]       cmp_idx_ff, cmp_idx_in;
   logic [IW-1:0]       sel_ff, sel_in;
   logic                lock_ff, lock_in;
   logic [STAMP_W-1:0]  oldest_ff, oldest_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic                stamp0_set_ff, stamp0_set_in;
   logic [STAMP_W-1:0]  clock_ff, clock_in;

   logic signed [COORD_W+1:0] col_ext, row_ext, col_lim, row_lim;
   logic                      in_grid;
   logic                      tag_hit;
   logic                      done;
   logic [7:0]                sel_wide;

   // grid bounds at full precision: origin <= coord < origin + count
   assign col_ext = $signed({{2{req_ff.col[COORD_W-1]}}, req_ff.col});
   assign row_ext = $signed({{2{req_ff.row[COORD_W-1]}}, req_ff.row});
   assign col_lim = $signed({{2{cfg.col_org[COORD_W-1]}}, cfg.col_org})
                  + $signed({{(COORD_W+2-COUNT_W){1'b0}}, cfg.cols});
   assign row_lim = $signed({{2{cfg.row_org[COORD_W-1]}}, cfg.row_org})
                  + $signed({{(COORD_W+2-COUNT_W){1'b0}}, cfg.rows});
   assign in_grid = (req_ff.col >= cfg.col_org) && (req_ff.row >= cfg.row_org)
                 && (col_ext < col_lim) && (row_ext < row_lim);

   assign tag_hit = valid_ff[cmp_idx_ff] && (ram_rd_data.rung == cfg.rung)
                 && (ram_rd_data.col == req_ff.col) && (ram_rd_data.row == req_ff.row);

   assign ram_rd_addr = rd_idx_ff;
   assign ram_wr_addr = sel_ff;
   assign ram_wr_data = '{rung: cfg.rung, col: req_ff.col, row: req_ff.row,
                          stamp: STAMP_W'(clock_ff + 1'b1)};

   assign req_chan.ready = (state_ff == ST_IDLE);

   assign sel_wide = 8'(sel_ff);
   assign result   = '{done: done, status: status_ff, slot: sel_wide[SLOT_W-1:0]};

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      sel_in        = sel_ff;
      lock_in       = lock_ff;
      oldest_in     = oldest_ff;
      status_in     = status_ff;
      valid_in      = valid_ff;
      stamp0_set_in = stamp0_set_ff;
      clock_in      = clock_ff;
      ram_wr_en     = 1'b0;
      done          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               req_in    = '{col: req_chan.tile_col, row: req_chan.tile_row,
                             offset: req_chan.index_offset, read_ok: req_chan.read_ok};
               rd_idx_in = '0;
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // slot 0 is read on this edge
            sel_in     = '0;
            rd_idx_in  = IW'(1);
            cmp_idx_in = '0;
            if (!in_grid) begin
               status_in = STAT_OUTSIDE;
               state_in  = ST_UPDATE;
            end else if (req_ff.offset == '0) begin
               status_in = STAT_BLANK;
               state_in  = ST_UPDATE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_idx_ff != LAST) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            cmp_idx_in = cmp_idx_ff + 1'b1;
            if (tag_hit) begin
               sel_in    = cmp_idx_ff;
               status_in = STAT_HIT;
               state_in  = ST_UPDATE;
            end else begin
               if (cmp_idx_ff == '0) begin
                  // slot 0 seeds the search even when empty
                  sel_in    = '0;
                  lock_in   = 1'b0;
                  oldest_in = stamp0_set_ff ? ram_rd_data.stamp : '0;
               end else if (!lock_ff) begin
                  if (!valid_ff[cmp_idx_ff]) begin
                     sel_in  = cmp_idx_ff;
                     lock_in = 1'b1;
                  end else if (ram_rd_data.stamp < oldest_ff) begin
                     sel_in    = cmp_idx_ff;
                     oldest_in = ram_rd_data.stamp;
                  end
               end
               if (cmp_idx_ff == LAST) begin
                  status_in = req_ff.read_ok ? STAT_FILL : STAT_FAIL;
                  state_in  = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               case (status_ff) inside
                  STAT_HIT, STAT_FILL: begin
                     ram_wr_en = 1'b1;
                     clock_in  = STAMP_W'(clock_ff + 1'b1);
                     if (sel_ff == '0) begin
                        stamp0_set_in = 1'b1;
                     end
                     if (status_ff == STAT_FILL) begin
                        valid_in[sel_ff] = 1'b1;
                     end
                  end
                  STAT_FAIL: begin
                     valid_in[sel_ff] = 1'b0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         stamp0_set_ff <= 1'b0;
         clock_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         stamp0_set_ff <= stamp0_set_in;
         clock_ff      <= clock_in;
      end
      req_ff     <= req_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      sel_ff     <= sel_in;
      lock_ff    <= lock_in;
      oldest_ff  <= oldest_in;
      status_ff  <= status_in;
   end

   `TCL_ASSERT_NEXT(a_fill_sets_valid, done && (status_ff == STAT_FILL), valid_ff[$past(sel_ff)], "filled slot not valid")
   `TCL_ASSERT_NEXT(a_fail_clears_valid, done && (status_ff == STAT_FAIL), !valid_ff[$past(sel_ff)], "failed slot still valid")
   `TCL_ASSERT_NEXT(a_clock_steady, !(done && (status_ff == STAT_HIT || status_ff == STAT_FILL)), $stable(clock_ff), "use clock moved without a stamp write")
   `TCL_ASSERT_NOW(a_hit_is_valid, done && (status_ff == STAT_HIT), valid_ff[sel_ff], "hit on an empty slot")

endmodule

// ===== design/tile_cache_lru_lookup_unit.sv =====
// Top level of the tile cache lookup: registers, sequencer, tag memory, output stage.
//
//   channel   dir   handshake          payload
//   req_chan  in    valid/ready        tile_col, tile_row, index_offset, read_ok
//   rsp_chan  out   valid/ready        status, slot
//   csr_*     in    csr_we (no wait)   csr_index, csr_wdata
//
// Timing: one item at a time. An item outside the grid or blank goes from the check
//   straight to the output register; any other first passes the scan, which ends
//   early on a hit and reads one slot per cycle from the tag memory. The input
//   reopens at the same edge that writes the result to the output register.
// Reset: synchronous; clears valid bits, use clock and sequencer. Memory is not
//   cleared; a flag stands in for the zero stamp of slot 0 until first written.
// Stalls: the output register holds one result; the next item is taken while it
//   waits, and the sequencer holds its write-back until the register frees.
module tile_cache_lru_lookup_unit #(
   parameter int SLOTS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   tcl_req_if.sink                         req_chan,
   tcl_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [tcl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcl_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import tcl_pkg::*;

   localparam int IW = $clog2(SLOTS);

   tcl_cfg_type         cfg_ff;
   tcl_result_type      result;
   logic                out_free;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   logic                ram_wr_en;
   logic [IW-1:0]       ram_wr_addr;
   logic [IW-1:0]       ram_rd_addr;
   tcl_entry_type       ram_wr_data;
   tcl_entry_type       ram_rd_data;

   // configuration registers; the user must write them only while the block is idle; the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{rung: '0, col_org: '0, row_org: '0,
                     cols: COUNT_W'(1), rows: COUNT_W'(1)};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ZOOM_RUNG: cfg_ff.rung    <= csr_wdata[RUNG_W-1:0];
            CSR_COL_ORG:   cfg_ff.col_org <= csr_wdata[COORD_W-1:0];
            CSR_ROW_ORG:   cfg_ff.row_org <= csr_wdata[COORD_W-1:0];
            CSR_COLS:      cfg_ff.cols    <= csr_wdata[COUNT_W-1:0];
            CSR_ROWS:      cfg_ff.rows    <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // output register: free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (result.done) begin
         rsp_status_ff <= result.status;
         rsp_slot_ff   <= result.slot;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.slot   = rsp_slot_ff;

   tcl_ctrl #(
      .SLOTS (SLOTS),
      .IW    (IW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .cfg         (cfg_ff),
      .out_free    (out_free),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   tcl_tag_ram #(
      .DEPTH (SLOTS),
      .AW    (IW)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== tb/sv/tile_cache_lru_lookup_unit_tb.sv =====
`timescale 1ns / 100ps
// Testbench of the tile cache lookup: directed table, random grid phases, LRU tag tracking.
module tile_cache_lru_lookup_unit_tb;
   import tcl_pkg::*;

   localparam int SLOTS       = 12;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 145;
   localparam int LONG_HOLD   = 400;
   localparam logic [COORD_W-1:0] COORD_MIN = 29'h10000000;
   localparam logic [COORD_W-1:0] COORD_MAX = 29'h0FFFFFFF;

   // one request item and one result item as the predictor sees them
   typedef struct {
      logic signed [COORD_W-1:0] col;
      logic signed [COORD_W-1:0] row;
      logic [OFFSET_W-1:0]       offset;
      logic                      ok;
   } tile_req_t;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
   } tile_res_t;

   // directed table row: either a register write or a request item
   typedef struct {
      bit                    is_reg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DAT_W-1:0]  data;
      tile_req_t             req;
      bit                    typed;
      tile_res_t             res;
   } dir_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   tcl_req_if req_chan ();
   tcl_rsp_if rsp_chan ();

   tile_cache_lru_lookup_unit #(.SLOTS(SLOTS)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor state: a shadow of the registers and of the tag store.
   // Tags are only compared while a way is live, so the never-written
   // contents of the tag fields are never looked at.
   // ---------------------------------------------------------------------
   logic [RUNG_W-1:0]         grid_rung;
   longint                    grid_col_org;
   longint                    grid_row_org;
   longint                    grid_cols;
   longint                    grid_rows;

   bit                        way_live  [SLOTS];
   logic [RUNG_W-1:0]         way_rung  [SLOTS];
   logic signed [COORD_W-1:0] way_col   [SLOTS];
   logic signed [COORD_W-1:0] way_row   [SLOTS];
   logic [STAMP_W-1:0]        way_stamp [SLOTS];
   logic [STAMP_W-1:0]        lru_clock;

   tile_res_t results_due[$];   // one entry per accepted item, oldest first
   dir_row_t  dir_rows[$];
   int        mismatches = 0;
   int        cycle_count = 0;

   // idle odds (percent) of the sender and of the receiver, set per phase
   int src_idle_pct = 0;
   int rcv_idle_pct = 0;
   // toggled by the stimulus to ask the receiver for one long hold-off
   bit stall_ask  = 1'b0;
   bit stall_seen = 1'b0;
   int hold_left  = 0;

   task automatic flag_mismatch(input string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Fully associative lookup with timestamp LRU; updates the shadow store.
   function automatic tile_res_t cache_lookup(input tile_req_t r);
      tile_res_t          res;
      longint             c;
      longint             w;
      int                 victim;
      logic [STAMP_W-1:0] oldest;
      c = longint'(r.col);
      w = longint'(r.row);
      res.status = STAT_OUTSIDE;
      res.slot   = '0;
      // bounds at full precision: origin + count may pass the 29-bit range
      if (c < grid_col_org || w < grid_row_org ||
          c >= grid_col_org + grid_cols || w >= grid_row_org + grid_rows)
         return res;
      if (r.offset == '0) begin
         res.status = STAT_BLANK;
         return res;
      end
      for (int i = 0; i < SLOTS; i++) begin
         if (way_live[i] && way_rung[i] == grid_rung &&
             way_col[i] == r.col && way_row[i] == r.row) begin
            lru_clock    = lru_clock + 1'b1;
            way_stamp[i] = lru_clock;
            res.status   = STAT_HIT;
            res.slot     = SLOT_W'(i);
            return res;
         end
      end
      // victim: first empty way from 1 up, else strictly lowest stamp from way 0
      victim = 0;
      oldest = way_stamp[0];
      for (int i = 1; i < SLOTS; i++) begin
         if (!way_live[i]) begin
            victim = i;
            break;
         end
         if (way_stamp[i] < oldest) begin
            oldest = way_stamp[i];
            victim = i;
         end
      end
      res.slot = SLOT_W'(victim);
      if (!r.ok) begin
         // failed fetch: way dropped, stamp and clock left alone
         way_live[victim] = 1'b0;
         res.status       = STAT_FAIL;
         return res;
      end
      way_live[victim]  = 1'b1;
      way_rung[victim]  = grid_rung;
      way_col[victim]   = r.col;
      way_row[victim]   = r.row;
      lru_clock         = lru_clock + 1'b1;
      way_stamp[victim] = lru_clock;
      res.status        = STAT_FILL;
      return res;
   endfunction

   // Register write; the shadow follows at once since the block is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         CSR_ZOOM_RUNG: grid_rung    = data[RUNG_W-1:0];
         CSR_COL_ORG:   grid_col_org = longint'($signed(data[COORD_W-1:0]));
         CSR_ROW_ORG:   grid_row_org = longint'($signed(data[COORD_W-1:0]));
         CSR_COLS:      grid_cols    = longint'(data[COUNT_W-1:0]);
         CSR_ROWS:      grid_rows    = longint'(data[COUNT_W-1:0]);
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Drop valid and wait until every result due has come back.
   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (results_due.size() > 0)
         @(posedge clock);
   endtask

   // Offer one item; on acceptance queue the typed or the predicted result.
   task automatic send_tile(input tile_req_t r, input bit typed, input tile_res_t want);
      tile_res_t guess;
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.tile_col     = r.col;
      req_chan.tile_row     = r.row;
      req_chan.index_offset = r.offset;
      req_chan.read_ok      = r.ok;
      do
         @(posedge clock);
      while (!req_chan.ready);
      guess = cache_lookup(r);
      results_due.push_back(typed ? want : guess);
   endtask

   task automatic add_tile(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                           input logic [OFFSET_W-1:0] offset, input logic ok,
                           input bit typed = 1'b0,
                           input logic [STATUS_W-1:0] status = STAT_OUTSIDE,
                           input logic [SLOT_W-1:0] slot = '0);
      dir_row_t d;
      d.is_reg     = 1'b0;
      d.idx        = '0;
      d.data       = '0;
      d.req.col    = col;
      d.req.row    = row;
      d.req.offset = offset;
      d.req.ok     = ok;
      d.typed      = typed;
      d.res.status = status;
      d.res.slot   = slot;
      dir_rows.push_back(d);
   endtask

   task automatic add_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      dir_row_t d;
      d = '{default: '0};
      d.is_reg = 1'b1;
      d.idx    = idx;
      d.data   = data;
      dir_rows.push_back(d);
   endtask

   // New grid for a random phase: every register written, junk above the rung and count fields.
   task automatic pick_grid(input int phase);
      logic [CSR_DAT_W-1:0] d;
      logic [COORD_W-1:0]   org [2];
      logic [COUNT_W-1:0]   cnt [2];
      int                   k;
      for (int a = 0; a < 2; a++) begin
         k = (phase == 0) ? 1 : (phase == 1) ? 2 : $urandom_range(0, 4);
         case (k)
            0: org[a] = '0;
            1: org[a] = COORD_MIN;
            2: org[a] = COORD_MAX - COORD_W'($urandom_range(0, 3));
            3: org[a] = COORD_W'($urandom);
            default: org[a] = COORD_W'($urandom_range(0, 40) - 20);
         endcase
         k = (phase == 0) ? 0 : $urandom_range(0, 15);
         case (k)
            0: cnt[a] = COUNT_W'(65536);
            1: cnt[a] = '1;
            2: cnt[a] = '0;
            default: cnt[a] = COUNT_W'($urandom_range(1, 6));
         endcase
      end
      d = CSR_DAT_W'($urandom);
      case ($urandom_range(0, 3))
         0: d[RUNG_W-1:0] = '0;
         1: d[RUNG_W-1:0] = '1;
         default: d[RUNG_W-1:0] = RUNG_W'($urandom_range(1, 3));
      endcase
      write_reg(CSR_ZOOM_RUNG, d);
      write_reg(CSR_COL_ORG, org[0]);
      write_reg(CSR_ROW_ORG, org[1]);
      d = CSR_DAT_W'($urandom);
      d[COUNT_W-1:0] = cnt[0];
      write_reg(CSR_COLS, d);
      d = CSR_DAT_W'($urandom);
      d[COUNT_W-1:0] = cnt[1];
      write_reg(CSR_ROWS, d);
   endtask

   // Random request: mostly a small pool of in-grid tiles (up to 5 by 5, more tiles
   // than ways on a wide grid, so hits and evictions both happen), plus edges, noise and blanks.
   function automatic tile_req_t roll_tile();
      tile_req_t r;
      longint    span_c;
      longint    span_r;
      int        cat;
      span_c = (grid_cols == 0) ? 1 : (grid_cols < 5 ? grid_cols : 5);
      span_r = (grid_rows == 0) ? 1 : (grid_rows < 5 ? grid_rows : 5);
      cat    = $urandom_range(0, 99);
      r.col    = COORD_W'(grid_col_org + longint'($urandom_range(0, int'(span_c) - 1)));
      r.row    = COORD_W'(grid_row_org + longint'($urandom_range(0, int'(span_r) - 1)));
      r.offset = $urandom;
      if (r.offset == '0)
         r.offset = 1;
      r.ok = ($urandom_range(0, 99) >= 15);
      if (cat >= 72 && cat < 80) begin
         // one step past an edge of the grid
         case ($urandom_range(0, 3))
            0: r.col = COORD_W'(grid_col_org - 1);
            1: r.col = COORD_W'(grid_col_org + grid_cols);
            2: r.row = COORD_W'(grid_row_org - 1);
            default: r.row = COORD_W'(grid_row_org + grid_rows);
         endcase
      end else if (cat >= 80 && cat < 90) begin
         r.col = COORD_W'($urandom);
         r.row = COORD_W'($urandom);
      end else if (cat >= 90) begin
         r.offset = '0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Receiver: random ready, with one long hold-off on request so the
   // output register and the sequencer fill and the input stalls.
   // ---------------------------------------------------------------------
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_ask != stall_seen) begin
            stall_seen = stall_ask;
            hold_left  = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // Result check: each accepted result against the oldest one due.
   always @(posedge clock) begin : rsp_check
      tile_res_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (results_due.size() == 0) begin
            flag_mismatch($sformatf("result with none due: status %0d slot %0d",
                                    rsp_chan.status, rsp_chan.slot));
         end else begin
            want = results_due.pop_front();
            if (rsp_chan.status !== want.status)
               flag_mismatch($sformatf("status %0d, expected %0d",
                                       rsp_chan.status, want.status));
            if (rsp_chan.slot !== want.slot)
               flag_mismatch($sformatf("slot %0d, expected %0d (status %0d)",
                                       rsp_chan.slot, want.slot, want.status));
         end
      end
   end

   // Watchdog: generous bound over the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL tile_cache_lru_lookup_unit");
         $finish;
      end
   end

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.tile_col     = '0;
      req_chan.tile_row     = '0;
      req_chan.index_offset = '0;
      req_chan.read_ok      = 1'b0;

      // shadow starts at the reset values
      grid_rung    = '0;
      grid_col_org = 0;
      grid_row_org = 0;
      grid_cols    = 1;
      grid_rows    = 1;
      lru_clock    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         way_live[i]  = 1'b0;
         way_stamp[i] = '0;
      end

      // --- directed table ---
      // reset grid is the single tile (0,0) of rung 0
      add_tile(0, 0, 1, 1'b1, 1'b1, STAT_FILL, 1);         // empty cache: way 1 first
      add_tile(0, 0, 7, 1'b1, 1'b1, STAT_HIT, 1);
      add_tile(1, 0, 7, 1'b1, 1'b1, STAT_OUTSIDE, 0);
      add_tile(0, '1, 7, 1'b1, 1'b1, STAT_OUTSIDE, 0);
      add_tile(0, 0, 0, 1'b1, 1'b1, STAT_BLANK, 0);
      add_tile(COORD_MIN, COORD_MAX, '1, 1'b1, 1'b1, STAT_OUTSIDE, 0);
      add_tile(0, 0, '1, 1'b0, 1'b1, STAT_HIT, 1);         // read_ok ignored on a hit
      // 65536 by 65536 grid at the coordinate extremes; row end passes the 29-bit range
      add_reg(CSR_COLS, 29'h10000);
      add_reg(CSR_ROWS, 29'h10000);
      add_reg(CSR_COL_ORG, COORD_MIN);
      add_reg(CSR_ROW_ORG, 29'h0FFF0000);
      add_tile(COORD_MIN, COORD_MAX, 1, 1'b1);
      add_tile(29'h10010000, COORD_MAX, 1, 1'b1, 1'b1, STAT_OUTSIDE, 0);
      add_tile(29'h1000FFFF, 29'h0FFEFFFF, 1, 1'b1, 1'b1, STAT_OUTSIDE, 0);
      add_tile(29'h10000001, 29'h0FFF0000, 9, 1'b0);        // failed fill
      add_tile(29'h1000FFFF, COORD_MAX, 3, 1'b1);
      // other rung: same coordinates miss; junk above the rung field
      add_reg(CSR_ZOOM_RUNG, '1);
      add_tile(COORD_MIN, COORD_MAX, 4, 1'b1);
      add_tile(COORD_MIN, COORD_MAX, 4, 1'b1);
      // zero column count: nothing is inside
      add_reg(CSR_COLS, '0);
      add_tile(COORD_MIN, COORD_MAX, 4, 1'b1, 1'b1, STAT_OUTSIDE, 0);
      // all-ones column count, used as given
      add_reg(CSR_COLS, '1);
      add_reg(CSR_ROWS, 1);
      add_reg(CSR_COL_ORG, 0);
      add_reg(CSR_ROW_ORG, 0);
      add_reg(CSR_ZOOM_RUNG, 0);
      add_tile(0, 0, 2, 1'b1);
      add_tile(29'h1FFFE, 0, 2, 1'b1);
      add_tile(29'h1FFFF, 0, 2, 1'b1, 1'b1, STAT_OUTSIDE, 0);
      add_tile(0, 0, 5, 1'b0);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      src_idle_pct = 37;
      rcv_idle_pct = 64;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_reg) begin
            wait_idle();
            write_reg(dir_rows[i].idx, dir_rows[i].data);
         end else begin
            send_tile(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
         end
      end

      // --- random phases: receiver-heavy idling, then sender-heavy, then none ---
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         pick_grid(p);
         if (p < 3) begin
            src_idle_pct = 37;
            rcv_idle_pct = 64;
         end else if (p < 6) begin
            src_idle_pct = 64;
            rcv_idle_pct = 37;
         end else begin
            src_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         // back-pressure: long receiver hold while items keep coming
         if (p == 6)
            stall_ask = ~stall_ask;
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_tile(roll_tile(), 1'b0, '{default: '0});
      end

      // --- drain ---
      wait_idle();
      repeat (SLOTS + 8) @(posedge clock);
      if (results_due.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", results_due.size()));
      if (mismatches == 0) begin
         $display("PASS tile_cache_lru_lookup_unit");
      end else begin
         $display("FAIL tile_cache_lru_lookup_unit");
      end
      $finish;
   end

endmodule

// ===== tile_cache_lru_lookup_unit.f =====
+incdir+design
design/tcl_pkg.sv
design/tcl_ifs.sv
design/tcl_tag_ram.sv
design/tcl_ctrl.sv
design/tile_cache_lru_lookup_unit.sv
tb/sv/tile_cache_lru_lookup_unit_tb.sv
